// File: rtl/core/assert_macros.svh
// Assertion helpers for the LED chain encoder checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define RGBENC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RGBENC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/rgbenc_pkg.sv
package rgbenc_pkg;

  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned BIT_SEL_W    = 5;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned ROW_W        = 3 * COLOR_W;
  localparam int unsigned DUTY_W       = 16;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned LED_COUNT_W  = 7;
  localparam int unsigned BRIGHT_W     = 9;
  localparam int unsigned INDEX_W      = 8;

  localparam logic [BRIGHT_W-1:0]    BRIGHT_FULL    = 9'd256;
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST  = 7'd1;
  localparam logic [BIT_SEL_W-1:0]   BIT_SEL_LAST   = 5'd23;

  typedef enum logic {
    KIND_SET_COLOR = 1'b0,
    KIND_TICK      = 1'b1
  } rgbenc_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_COUNT     = 2'd0,
    CFG_BRIGHTNESS    = 2'd1,
    CFG_BIT_ONE_DUTY  = 2'd2,
    CFG_BIT_ZERO_DUTY = 2'd3
  } rgbenc_cfg_idx_t;

  typedef struct packed {
    logic                 data_slot;
    logic                 frame_last;
    logic [BIT_SEL_W-1:0] bit_sel;
  } rgbenc_slot_t;

endpackage

// File: rtl/core/rgbenc_color_store.sv
module rgbenc_color_store #(
  parameter int unsigned MAX_LEDS = 64,
  parameter int unsigned AW       = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [rgbenc_pkg::COLOR_W-1:0]  wr_red,
  input  logic [rgbenc_pkg::COLOR_W-1:0]  wr_green,
  input  logic [rgbenc_pkg::COLOR_W-1:0]  wr_blue,
  input  logic [rgbenc_pkg::BRIGHT_W-1:0] brightness,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [rgbenc_pkg::ROW_W-1:0]    row_q
);
  import rgbenc_pkg::*;

  logic [ROW_W-1:0]    mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] valid_r;
  logic [ROW_W-1:0]    rd_data_r;
  logic                rd_valid_r;
  logic [BRIGHT_W-1:0] bright_eff;
  logic [COLOR_W+BRIGHT_W-1:0] prod_r, prod_g, prod_b;
  logic [ROW_W-1:0]    wr_row;

  always_comb begin
    bright_eff = (brightness > BRIGHT_FULL) ? BRIGHT_FULL : brightness;
    prod_r = {{BRIGHT_W{1'b0}}, wr_red}   * {{COLOR_W{1'b0}}, bright_eff};
    prod_g = {{BRIGHT_W{1'b0}}, wr_green} * {{COLOR_W{1'b0}}, bright_eff};
    prod_b = {{BRIGHT_W{1'b0}}, wr_blue}  * {{COLOR_W{1'b0}}, bright_eff};
    // stored green, red, blue; green in the top byte
    wr_row = {prod_g[COLOR_W +: COLOR_W], prod_r[COLOR_W +: COLOR_W],
              prod_b[COLOR_W +: COLOR_W]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign row_q = rd_valid_r ? rd_data_r : '0;

endmodule

// File: rtl/core/rgbenc_frame_seq.sv
module rgbenc_frame_seq #(
  parameter int unsigned MAX_LEDS  = 64,
  parameter int unsigned PAD_SLOTS = 30,
  parameter int unsigned NW        = 7,
  parameter int unsigned AW        = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [NW-1:0]              n_eff,
  output rgbenc_pkg::rgbenc_slot_t   slot,
  output logic [AW-1:0]              led_addr
);
  import rgbenc_pkg::*;

  localparam int unsigned LAST_MAX = 2 * PAD_SLOTS + BITS_PER_LED * MAX_LEDS;
  localparam int unsigned PW       = $clog2(LAST_MAX + 1);
  localparam int unsigned LCW      = $clog2(MAX_LEDS + PAD_SLOTS / BITS_PER_LED + 3);

  logic [PW-1:0]        pos_r, pos_nxt;
  logic [LCW-1:0]       led_r, led_nxt;
  logic [BIT_SEL_W-1:0] bit_r, bit_nxt;
  logic [PW-1:0]        last_pos;
  logic                 past_pad;

  always_comb begin
    last_pos = PW'(2 * PAD_SLOTS) + (PW'(n_eff) << 4) + (PW'(n_eff) << 3);
    past_pad = (pos_r >= PW'(PAD_SLOTS));
    slot.data_slot  = past_pad && (32'(led_r) < 32'(n_eff));
    slot.frame_last = (pos_r >= last_pos);
    slot.bit_sel    = bit_r;
    led_addr        = AW'(led_r);

    pos_nxt = pos_r;
    led_nxt = led_r;
    bit_nxt = bit_r;
    if (advance) begin
      if (slot.frame_last) begin
        pos_nxt = '0;
        led_nxt = '0;
        bit_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (past_pad) begin
          if (bit_r == BIT_SEL_LAST) begin
            bit_nxt = '0;
            led_nxt = led_r + 1'b1;
          end else begin
            bit_nxt = bit_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      led_r <= '0;
      bit_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      led_r <= led_nxt;
      bit_r <= bit_nxt;
    end
  end

endmodule

// File: rtl/core/rgb_led_chain_bit_encoder.sv
// A tick gives its duty on out_valid through the color store read register, then the
// output register. A set-color request gives no result. Throughput: one request per
// cycle while in_stall is low; the color store has one write and one read port.
// Reset (synchronous, rst_n low) resets config and valid flags, frame position and the
// per-LED valid bits, so all colors read as zero; no clearing pass is needed.
module rgb_led_chain_bit_encoder #(
  parameter int unsigned MAX_LEDS  = 64,
  parameter int unsigned PAD_SLOTS = 30
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rgbenc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbenc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [rgbenc_pkg::INDEX_W-1:0]    in_led_index,
  input  logic [rgbenc_pkg::COLOR_W-1:0]    in_red,
  input  logic [rgbenc_pkg::COLOR_W-1:0]    in_green,
  input  logic [rgbenc_pkg::COLOR_W-1:0]    in_blue,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rgbenc_pkg::DUTY_W-1:0]     out_duty,
  output logic                              out_frame_last
);
  import rgbenc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_LEDS + 1);
  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic [LED_COUNT_W-1:0] led_count_r;
  logic [BRIGHT_W-1:0]    brightness_r;
  logic [DUTY_W-1:0]      one_duty_r;
  logic [DUTY_W-1:0]      zero_duty_r;

  logic [NW-1:0]    n_eff;
  logic [AW-1:0]    wr_addr;
  logic             in_fire, tick_fire, set_fire;
  logic             s1_valid_r, out_valid_r;
  rgbenc_slot_t     slot, s1_slot_r;
  logic [AW-1:0]    led_addr;
  logic [ROW_W-1:0] row_q;
  logic             out_adv, s1_adv;
  logic             bit_val;
  logic [DUTY_W-1:0] duty_nxt;
  logic [DUTY_W-1:0] out_duty_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r  <= LED_COUNT_RST;
      brightness_r <= BRIGHT_FULL;
      one_duty_r   <= '0;
      zero_duty_r  <= '0;
    end else if (cfg_we) begin
      unique case (rgbenc_cfg_idx_t'(cfg_index))
        CFG_LED_COUNT:     led_count_r  <= cfg_wdata[LED_COUNT_W-1:0];
        CFG_BRIGHTNESS:    brightness_r <= cfg_wdata[BRIGHT_W-1:0];
        CFG_BIT_ONE_DUTY:  one_duty_r   <= cfg_wdata;
        CFG_BIT_ZERO_DUTY: zero_duty_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (led_count_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(led_count_r) > 32'(MAX_LEDS)) begin
      n_eff = NW'(MAX_LEDS);
    end else begin
      n_eff = NW'(led_count_r);
    end
    if (32'(in_led_index) >= 32'(n_eff)) begin
      wr_addr = AW'(n_eff - 1'b1);
    end else begin
      wr_addr = AW'(in_led_index);
    end
  end

  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_stall  = !s1_adv;
  assign in_fire   = in_valid && !in_stall;
  assign tick_fire = in_fire && (rgbenc_kind_t'(in_kind) == KIND_TICK);
  assign set_fire  = in_fire && (rgbenc_kind_t'(in_kind) == KIND_SET_COLOR);

  rgbenc_frame_seq #(
    .MAX_LEDS  (MAX_LEDS),
    .PAD_SLOTS (PAD_SLOTS),
    .NW        (NW),
    .AW        (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (tick_fire),
    .n_eff    (n_eff),
    .slot     (slot),
    .led_addr (led_addr)
  );

  rgbenc_color_store #(
    .MAX_LEDS (MAX_LEDS),
    .AW       (AW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (set_fire),
    .wr_addr    (wr_addr),
    .wr_red     (in_red),
    .wr_green   (in_green),
    .wr_blue    (in_blue),
    .brightness (brightness_r),
    .rd_en      (tick_fire),
    .rd_addr    (led_addr),
    .row_q      (row_q)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_slot_r <= slot;
    end
    if (out_adv && s1_valid_r) begin
      out_duty_r <= duty_nxt;
      out_last_r <= s1_slot_r.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= tick_fire;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_comb begin
    bit_val = row_q[BIT_SEL_LAST - s1_slot_r.bit_sel];
    if (!s1_slot_r.data_slot) begin
      duty_nxt = '0;
    end else if (bit_val) begin
      duty_nxt = one_duty_r;
    end else begin
      duty_nxt = zero_duty_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_duty       = out_duty_r;
  assign out_frame_last = out_last_r;

endmodule

// File: rtl/core/rgbenc_chk.sv
`include "assert_macros.svh"

module rgbenc_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rgbenc_pkg::DUTY_W-1:0] out_duty,
  input logic                         out_frame_last
);
  import rgbenc_pkg::*;

  `RGBENC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall, "output not empty after reset")
  `RGBENC_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled with room in the output")
  `RGBENC_ASSERT(a_valid_holds, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")
  `RGBENC_ASSERT(a_payload_holds, clk, rst_n, (out_valid && out_stall) |=> ($stable(out_duty) && $stable(out_frame_last)), "stalled result changed")

endmodule

bind rgb_led_chain_bit_encoder rgbenc_chk u_rgbenc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_duty       (out_duty),
  .out_frame_last (out_frame_last)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rgbenc_pkg::*;

  localparam int unsigned TB_MAX_LEDS  = 64;
  localparam int unsigned TB_PAD_SLOTS = 30;
  localparam int unsigned RANDOM_ITEMS = 600;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              frame_last;
  } duty_slot_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = 1'b0;
  logic [INDEX_W-1:0]   in_led_index = '0;
  logic [COLOR_W-1:0]   in_red = '0;
  logic [COLOR_W-1:0]   in_green = '0;
  logic [COLOR_W-1:0]   in_blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DUTY_W-1:0]    out_duty;
  logic                 out_frame_last;

  // predicted block state
  logic [LED_COUNT_W-1:0] chain_leds;
  logic [BRIGHT_W-1:0]    bright_q8;
  logic [DUTY_W-1:0]      one_duty;
  logic [DUTY_W-1:0]      zero_duty;
  logic [COLOR_W-1:0]     grb_store [3*TB_MAX_LEDS];
  int unsigned            frame_pos;

  duty_slot_t  pending_slots[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  rgb_led_chain_bit_encoder #(
    .MAX_LEDS (TB_MAX_LEDS),
    .PAD_SLOTS(TB_PAD_SLOTS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_led_index  (in_led_index),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_duty      (out_duty),
    .out_frame_last(out_frame_last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned chain_length();
    int unsigned n;
    n = chain_leds;
    if (n == 0) n = 1;
    if (n > TB_MAX_LEDS) n = TB_MAX_LEDS;
    return n;
  endfunction

  function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] c);
    logic [BRIGHT_W-1:0] b;
    logic [16:0]         p;
    b = (bright_q8 > BRIGHT_FULL) ? BRIGHT_FULL : bright_q8;
    p = c * b;
    return p[15:8];
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return COLOR_W'($urandom_range(0, 255));
  endfunction

  function automatic void reset_prediction();
    chain_leds = LED_COUNT_RST;
    bright_q8  = BRIGHT_FULL;
    one_duty   = '0;
    zero_duty  = '0;
    foreach (grb_store[i]) grb_store[i] = '0;
    frame_pos  = 0;
  endfunction

  function automatic void predict_request(input rgbenc_kind_t kind,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic [COLOR_W-1:0] r, g, b);
    int unsigned n;
    int unsigned led;
    int unsigned data_slots;
    int unsigned last_pos;
    int unsigned bit_num;
    int unsigned k;
    logic [COLOR_W-1:0] color_byte;
    duty_slot_t slot;
    n = chain_length();
    if (kind == KIND_SET_COLOR) begin
      led = (idx >= n) ? n - 1 : idx;
      grb_store[led*3]     = scale_color(g);
      grb_store[led*3 + 1] = scale_color(r);
      grb_store[led*3 + 2] = scale_color(b);
    end else begin
      data_slots = n * BITS_PER_LED;
      last_pos   = 2 * TB_PAD_SLOTS + data_slots;
      slot.duty  = '0;
      if (frame_pos >= TB_PAD_SLOTS && frame_pos < TB_PAD_SLOTS + data_slots) begin
        bit_num    = frame_pos - TB_PAD_SLOTS;
        led        = bit_num / BITS_PER_LED;
        k          = bit_num % BITS_PER_LED;
        color_byte = grb_store[led*3 + k/8];
        slot.duty  = color_byte[7 - k%8] ? one_duty : zero_duty;
      end
      slot.frame_last = (frame_pos >= last_pos);
      frame_pos = slot.frame_last ? 0 : frame_pos + 1;
      pending_slots.push_back(slot);
    end
  endfunction

  task automatic send_request(input rgbenc_kind_t kind, input logic [INDEX_W-1:0] idx,
                              input logic [COLOR_W-1:0] r, g, b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_led_index <= idx;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    do @(posedge clk); while (in_stall);
    predict_request(kind, idx, r, g, b);
  endtask

  task automatic send_tick();
    send_request(KIND_TICK, INDEX_W'($urandom_range(0, 255)), pick_color(), pick_color(),
                 pick_color());
  endtask

  task automatic tick_to_frame_end();
    do send_tick(); while (frame_pos != 0);
  endtask

  // wait until every tick has come back and the pipe is empty
  task automatic drain_requests();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rgbenc_cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LED_COUNT:     chain_leds = val[LED_COUNT_W-1:0];
      CFG_BRIGHTNESS:    bright_q8  = val[BRIGHT_W-1:0];
      CFG_BIT_ONE_DUTY:  one_duty   = val;
      CFG_BIT_ZERO_DUTY: zero_duty  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    repeat (3) send_tick();
    send_request(KIND_SET_COLOR, 8'd0, 8'h00, 8'h00, 8'h00);
  endtask

  // zero count, brightness above one, index clamped, full-scale duties
  task automatic test_clamp_and_extremes();
    drain_requests();
    write_reg(CFG_LED_COUNT, 16'd0);
    write_reg(CFG_BRIGHTNESS, 16'd511);
    write_reg(CFG_BIT_ONE_DUTY, 16'hFFFF);
    write_reg(CFG_BIT_ZERO_DUTY, 16'h0000);
    send_request(KIND_SET_COLOR, 8'hFF, 8'hFF, 8'h00, 8'hA5);
    tick_to_frame_end();
    send_request(KIND_SET_COLOR, 8'h00, 8'h00, 8'hFF, 8'h5A);
    tick_to_frame_end();
  endtask

  task automatic test_brightness_scaling();
    drain_requests();
    write_reg(CFG_LED_COUNT, 16'd2);
    write_reg(CFG_BRIGHTNESS, 16'd0);
    write_reg(CFG_BIT_ONE_DUTY, 16'h1234);
    write_reg(CFG_BIT_ZERO_DUTY, 16'hEDCB);
    send_request(KIND_SET_COLOR, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    tick_to_frame_end();
    drain_requests();
    write_reg(CFG_BRIGHTNESS, 16'd129);
    send_request(KIND_SET_COLOR, 8'd0, 8'hFF, 8'h80, 8'h01);
    send_request(KIND_SET_COLOR, 8'd1, 8'h7F, 8'hC3, 8'hFE);
    tick_to_frame_end();
    drain_requests();
    write_reg(CFG_BRIGHTNESS, 16'd256);
    send_request(KIND_SET_COLOR, 8'd2, 8'h81, 8'h3C, 8'hFF);
    tick_to_frame_end();
  endtask

  // shrink the chain while the position is past the new frame end
  task automatic test_count_change_mid_frame();
    drain_requests();
    write_reg(CFG_LED_COUNT, 16'd127);
    while (frame_pos != 200) send_tick();
    drain_requests();
    write_reg(CFG_LED_COUNT, 16'd1);
    repeat (4) send_tick();
  endtask

  task automatic test_full_chain();
    drain_requests();
    write_reg(CFG_LED_COUNT, 16'd64);
    write_reg(CFG_BIT_ONE_DUTY, 16'h8001);
    write_reg(CFG_BIT_ZERO_DUTY, 16'h7FFE);
    send_request(KIND_SET_COLOR, 8'd0, 8'hF0, 8'h0F, 8'hAA);
    send_request(KIND_SET_COLOR, 8'd62, 8'h55, 8'hCC, 8'h33);
    send_request(KIND_SET_COLOR, 8'd64, 8'h01, 8'h80, 8'hFF);
    send_request(KIND_SET_COLOR, 8'd255, 8'h96, 8'h69, 8'hE7);
    tick_to_frame_end();
  endtask

  task automatic randomize_config();
    int unsigned pick;
    logic [CFG_W-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick < 6) v = CFG_W'($urandom_range(1, 4));
    else if (pick == 6) v = '0;
    else if (pick == 7) v = CFG_W'(TB_MAX_LEDS);
    else if (pick == 8) v = CFG_W'($urandom_range(65, 127));
    else v = CFG_W'($urandom_range(5, 63));
    if ($urandom_range(0, 3) == 0) v[CFG_W-1:LED_COUNT_W] = '1;
    write_reg(CFG_LED_COUNT, v);
    pick = $urandom_range(0, 9);
    if (pick == 0) v = '0;
    else if (pick < 3) v = CFG_W'(BRIGHT_FULL);
    else if (pick == 3) v = CFG_W'($urandom_range(257, 511));
    else v = CFG_W'($urandom_range(1, 255));
    if ($urandom_range(0, 3) == 0) v[CFG_W-1:BRIGHT_W] = '1;
    write_reg(CFG_BRIGHTNESS, v);
    pick = $urandom_range(0, 9);
    v = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_W'($urandom_range(0, 65535));
    write_reg(CFG_BIT_ONE_DUTY, v);
    pick = $urandom_range(0, 9);
    v = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_W'($urandom_range(0, 65535));
    write_reg(CFG_BIT_ZERO_DUTY, v);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned n;
    logic [INDEX_W-1:0] idx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_requests();
      randomize_config();
      repeat ($urandom_range(30, 90)) begin
        n = chain_length();
        if ($urandom_range(0, 9) < 3) begin
          idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, 255))
                                            : INDEX_W'($urandom_range(0, n - 1));
          send_request(KIND_SET_COLOR, idx, pick_color(), pick_color(), pick_color());
        end else begin
          send_tick();
        end
        sent++;
      end
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin : check_slots
    duty_slot_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_slots.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result duty %h frame_last %b", $time, out_duty,
                 out_frame_last);
      end else begin
        want = pending_slots.pop_front();
        if (out_duty !== want.duty) begin
          mismatch_count++;
          $display("%0t: duty expected %h actual %h", $time, want.duty, out_duty);
        end
        if (out_frame_last !== want.frame_last) begin
          mismatch_count++;
          $display("%0t: frame_last expected %b actual %b", $time, want.frame_last,
                   out_frame_last);
        end
      end
    end
  end

  initial begin
    reset_prediction();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_clamp_and_extremes();
    test_brightness_scaling();
    test_count_change_mid_frame();
    test_full_chain();
    test_random_traffic();
    drain_requests();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_slots.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: rgb_led_chain_bit_encoder.f
+incdir+rtl/core
rtl/core/rgbenc_pkg.sv
rtl/core/rgbenc_color_store.sv
rtl/core/rgbenc_frame_seq.sv
rtl/core/rgb_led_chain_bit_encoder.sv
rtl/core/rgbenc_chk.sv
verif/testbench.sv
